FILE: design/somr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// somr_pkg: shared types and constants of the spiral-order matrix reader
// Field widths, register indexes, walk directions and the command/status
// words between controller and datapath.
// ----------------------------------------------------------------------------
package somr_pkg;

    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLUMNS = 8;

    localparam int VALUE_W = 32;
    localparam int COORD_W = 3;
    localparam int DIM_W   = 4;
    localparam int COUNT_W = 7;

    typedef enum logic [0:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef struct packed {
        logic load;
        logic begin_walk;
        logic step;
    } somr_cmd_t;

    typedef struct packed {
        logic load_last;
        logic walk_last;
    } somr_status_t;

endpackage

FILE: design/somr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// somr_ctrl: sequencing of load and spiral walk
// Accepts elements while idle and runs one walk step per cycle once the
// matrix is complete.
// ----------------------------------------------------------------------------
module somr_ctrl
    import somr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  somr_status_t status,
    output somr_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.load_last)
                    begin
                        cmd.begin_walk = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: design/somr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// somr_datapath: element store, load counters and spiral walker
// Holds the matrix in a memory, tracks visited cells in flops and
// registers one result word per walk step.
// ----------------------------------------------------------------------------
module somr_datapath
    import somr_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [0:0]                cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    input  logic signed [VALUE_W-1:0] element_value,
    input  somr_cmd_t                 cmd,
    output somr_status_t              status,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_column,
    output logic                      is_last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] MAX_ROWS_DIM    = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAX_COLUMNS_DIM = DIM_W'(MAX_COLUMNS);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
        return ADDR_W'(r * MAX_COLUMNS + c);
    endfunction

    logic [DIM_W-1:0]   row_count_reg;
    logic [DIM_W-1:0]   column_count_reg;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [COUNT_W-1:0] total;

    logic [COORD_W-1:0] load_row_reg;
    logic [COORD_W-1:0] load_col_reg;

    logic [COORD_W-1:0] walk_row_reg;
    logic [COORD_W-1:0] walk_col_reg;
    logic [COORD_W-1:0] walk_row_next;
    logic [COORD_W-1:0] walk_col_next;
    dir_t               dir_reg;
    dir_t               dir_next;
    logic [COUNT_W-1:0] step_count_reg;
    logic [DEPTH-1:0]   visited_reg;

    logic signed [VALUE_W-1:0] store [DEPTH];
    logic signed [VALUE_W-1:0] read_data_reg;
    logic [ADDR_W-1:0]         write_addr;
    logic [ADDR_W-1:0]         walk_addr;

    logic               out_valid_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_column_reg;
    logic               is_last_reg;

    logic [DIM_W-1:0] r_ext;
    logic [DIM_W-1:0] c_ext;
    logic             go_on;

    // Out-of-range dimensions: zero reads as one, above max reads as max
    always_comb
    begin
        if (row_count_reg == '0)
            rows = DIM_W'(1);
        else if (row_count_reg > MAX_ROWS_DIM)
            rows = MAX_ROWS_DIM;
        else
            rows = row_count_reg;
        if (column_count_reg == '0)
            cols = DIM_W'(1);
        else if (column_count_reg > MAX_COLUMNS_DIM)
            cols = MAX_COLUMNS_DIM;
        else
            cols = column_count_reg;
    end

    assign total = COUNT_W'(rows) * COUNT_W'(cols);

    assign status.load_last = ({1'b0, load_row_reg} == rows - DIM_W'(1)) &&
                              ({1'b0, load_col_reg} == cols - DIM_W'(1));
    assign status.walk_last = (step_count_reg == total - COUNT_W'(1));

    assign write_addr = addr_of({1'b0, load_row_reg}, {1'b0, load_col_reg});
    assign walk_addr  = addr_of({1'b0, walk_row_reg}, {1'b0, walk_col_reg});

    // Next walk position: keep heading while the cell ahead is free, else turn
    always_comb
    begin
        r_ext         = {1'b0, walk_row_reg};
        c_ext         = {1'b0, walk_col_reg};
        go_on         = 1'b0;
        walk_row_next = walk_row_reg;
        walk_col_next = walk_col_reg;
        case (dir_reg)
            DIR_RIGHT:
                go_on = (c_ext + DIM_W'(1) < cols) &&
                        !visited_reg[addr_of(r_ext, c_ext + DIM_W'(1))];
            DIR_DOWN:
                go_on = (r_ext + DIM_W'(1) < rows) &&
                        !visited_reg[addr_of(r_ext + DIM_W'(1), c_ext)];
            DIR_LEFT:
                go_on = (c_ext != '0) &&
                        !visited_reg[addr_of(r_ext, c_ext - DIM_W'(1))];
            DIR_UP:
                go_on = (r_ext != '0) &&
                        !visited_reg[addr_of(r_ext - DIM_W'(1), c_ext)];
            default:
                go_on = 1'b0;
        endcase
        dir_next = go_on ? dir_reg : dir_t'(dir_reg + 2'd1);
        // Move one cell toward dir_next, clamped to the matrix
        case (dir_next)
            DIR_RIGHT:
                walk_col_next = (c_ext + DIM_W'(1) >= cols) ?
                                COORD_W'(cols - DIM_W'(1)) : walk_col_reg + COORD_W'(1);
            DIR_DOWN:
                walk_row_next = (r_ext + DIM_W'(1) >= rows) ?
                                COORD_W'(rows - DIM_W'(1)) : walk_row_reg + COORD_W'(1);
            DIR_LEFT:
                walk_col_next = (walk_col_reg == '0) ? '0 : walk_col_reg - COORD_W'(1);
            DIR_UP:
                walk_row_next = (walk_row_reg == '0) ? '0 : walk_row_reg - COORD_W'(1);
            default:
                walk_row_next = walk_row_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_W'(1);
            column_count_reg <= DIM_W'(1);
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            walk_row_reg     <= '0;
            walk_col_reg     <= '0;
            dir_reg          <= DIR_RIGHT;
            step_count_reg   <= '0;
            visited_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.step;
            if (cfg_write)
            begin
                // Any register write drops a partly loaded matrix
                case (reg_index_t'(cfg_index))
                    REG_ROW_COUNT:
                    begin
                        row_count_reg <= cfg_data;
                        load_row_reg  <= '0;
                        load_col_reg  <= '0;
                    end
                    REG_COLUMN_COUNT:
                    begin
                        column_count_reg <= cfg_data;
                        load_row_reg     <= '0;
                        load_col_reg     <= '0;
                    end
                    default:
                    begin
                        load_row_reg <= load_row_reg;
                    end
                endcase
            end
            else if (cmd.load)
            begin
                if (status.load_last)
                begin
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                end
                else if ({1'b0, load_col_reg} == cols - DIM_W'(1))
                begin
                    load_col_reg <= '0;
                    load_row_reg <= load_row_reg + COORD_W'(1);
                end
                else
                begin
                    load_col_reg <= load_col_reg + COORD_W'(1);
                end
            end
            if (cmd.begin_walk)
            begin
                walk_row_reg   <= '0;
                walk_col_reg   <= '0;
                dir_reg        <= DIR_RIGHT;
                step_count_reg <= '0;
                visited_reg    <= '0;
            end
            else if (cmd.step)
            begin
                walk_row_reg           <= walk_row_next;
                walk_col_reg           <= walk_col_next;
                dir_reg                <= dir_next;
                step_count_reg         <= step_count_reg + COUNT_W'(1);
                visited_reg[walk_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store[write_addr] <= element_value;
        end
        if (cmd.step)
        begin
            read_data_reg <= store[walk_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_row_reg    <= walk_row_reg;
            out_column_reg <= walk_col_reg;
            is_last_reg    <= status.walk_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = read_data_reg;
    assign out_row    = out_row_reg;
    assign out_column = out_column_reg;
    assign is_last    = is_last_reg;

endmodule

FILE: design/spiral_order_matrix_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader: store a matrix, replay it in spiral order
// Loads a row_count by column_count matrix word by word and then emits
// every element clockwise from the top-left corner.
// ----------------------------------------------------------------------------
// Usage:
//   Write row_count (index 0) and column_count (index 1) through cfg_write,
//   cfg_index and cfg_data while the block is idle; any write restarts the
//   load of a matrix. Present elements in row-major order on element_value
//   with start; a word is taken at a clock edge where start is high and
//   busy is low, one word per cycle.
//   The word that completes the matrix starts the walk: busy rises and stays
//   high until every element is visited, one walk step per cycle, bounded by
//   the single read port of the element store. The first result is on the
//   ports from the edge after the one that takes the last word, then one
//   result per cycle, each for exactly one cycle with out_valid high; is_last
//   marks the final one. The receiver cannot stall: results are not held and
//   must be taken as they come. Reset sets both dimensions to one, empties the
//   load count and clears the visited map; store contents are undefined
//   until loaded.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader
    import somr_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [0:0]                cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    input  logic                      start,
    input  logic signed [VALUE_W-1:0] element_value,
    output logic                      busy,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_column,
    output logic                      is_last
);

    somr_cmd_t    cmd;
    somr_status_t status;

    somr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    somr_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (element_value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_column    (out_column),
        .is_last       (is_last)
    );

    // A result word only follows a walk step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
    else $error("result word without a walk step");

    // A burst runs without gaps until its last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_last) |=> out_valid)
    else $error("gap inside a spiral burst");

    // The last word of a burst is never directly followed by another result word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_last) |=> !out_valid)
    else $error("result word right after the last word of a burst");

    // Words are never taken while the walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load)
    else $error("element loaded during a walk");

endmodule
